@@ sv/fbc_pkg.sv @@
`timescale 1ns / 1ps

package fbc_pkg;

  localparam int unsigned BLOCK_W        = 64;
  localparam int unsigned KEY_W          = 64;
  localparam int unsigned KEY_COUNT      = 4;
  localparam int unsigned KEY_IDX_W      = 2;
  localparam int unsigned ROUNDS_DEF     = 4;
  localparam int unsigned HALF_BYTES_DEF = 8;

  typedef enum logic [KEY_IDX_W-1:0] {
    REG_ROUND_KEY_0 = 2'd0,
    REG_ROUND_KEY_1 = 2'd1,
    REG_ROUND_KEY_2 = 2'd2,
    REG_ROUND_KEY_3 = 2'd3
  } cfg_reg_t;

  typedef logic [KEY_COUNT-1:0][KEY_W-1:0] key_set_t;

  typedef struct packed {
    logic               func;
    logic [BLOCK_W-1:0] block_left;
    logic [BLOCK_W-1:0] block_right;
  } in_item_t;

  typedef struct packed {
    logic [BLOCK_W-1:0] result_left;
    logic [BLOCK_W-1:0] result_right;
  } out_item_t;

endpackage

@@ sv/fbc_key_file.sv @@
`timescale 1ns / 1ps

module fbc_key_file import fbc_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  output key_set_t             keys
);

  key_set_t keys_r;
  key_set_t keys_nxt;

  always_comb begin
    keys_nxt = keys_r;
    if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_ROUND_KEY_0: keys_nxt[0] = cfg_data;
        REG_ROUND_KEY_1: keys_nxt[1] = cfg_data;
        REG_ROUND_KEY_2: keys_nxt[2] = cfg_data;
        REG_ROUND_KEY_3: keys_nxt[3] = cfg_data;
        default:         keys_nxt    = keys_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      keys_r <= '0;
    end else begin
      keys_r <= keys_nxt;
    end
  end

  assign keys = keys_r;

endmodule

@@ sv/fbc_round_stage.sv @@
`timescale 1ns / 1ps

module fbc_round_stage import fbc_pkg::*; #(
  parameter int unsigned HALF_BYTES = HALF_BYTES_DEF,
  parameter int unsigned KEY_ENC    = 0,
  parameter int unsigned KEY_DEC    = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  key_set_t                keys,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    in_func,
  input  logic [8*HALF_BYTES-1:0] in_left,
  input  logic [8*HALF_BYTES-1:0] in_right,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic                    out_func,
  output logic [8*HALF_BYTES-1:0] out_left,
  output logic [8*HALF_BYTES-1:0] out_right
);

  localparam int unsigned HALF_W = 8 * HALF_BYTES;
  localparam logic [KEY_IDX_W-1:0] KE = KEY_ENC[KEY_IDX_W-1:0];
  localparam logic [KEY_IDX_W-1:0] KD = KEY_DEC[KEY_IDX_W-1:0];

  logic              valid_r;
  logic              valid_nxt;
  logic              func_r;
  logic [HALF_W-1:0] left_r;
  logic [HALF_W-1:0] right_r;
  logic [HALF_W-1:0] right_nxt;
  logic [HALF_W-1:0] key;
  logic              load;

  assign in_ready  = !valid_r || out_ready;
  assign load      = in_valid && in_ready;
  assign valid_nxt = in_ready ? in_valid : valid_r;
  assign key       = in_func ? keys[KD][HALF_W-1:0] : keys[KE][HALF_W-1:0];

  // Bytewise multiply by the round key, keep the low byte of each product and XOR it with the left half.
  always_comb begin
    logic [15:0] prod;
    right_nxt = '0;
    for (int j = 0; j < int'(HALF_BYTES); j++) begin
      prod = in_right[8*j +: 8] * key[8*j +: 8];
      right_nxt[8*j +: 8] = in_left[8*j +: 8] ^ prod[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      func_r  <= in_func;
      left_r  <= in_right;
      right_r <= right_nxt;
    end
  end

  assign out_valid = valid_r;
  assign out_func  = func_r;
  assign out_left  = left_r;
  assign out_right = right_r;

  // Hold a stalled request and its data until taken.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !out_ready |=> valid_r && $stable(left_r) && $stable(right_r)
                              && $stable(func_r))
    else $error("stalled stage lost or changed its request");

  a_load_valid: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> valid_r)
    else $error("accepted request did not become valid");

  a_drop_only_taken: assert property (@(posedge clk) disable iff (!rst_n)
    valid_r && !in_valid |=> !valid_r || $past(!out_ready))
    else $error("stage dropped or kept a request against downstream ready");

endmodule

@@ sv/feistel_block_cipher_4round.sv @@
`timescale 1ns / 1ps

// Feistel block cipher, one 16-byte block per request. Each of the ROUNDS
// rounds (4 by default) is one pipeline register stage (bytewise 8x8
// multiply by the round key, then XOR), and a new block is taken every cycle
// while the result side keeps up. Each stage has its own valid bit and a stall
// backs up stage by stage; the last round stage is the output register. Round
// keys are written through cfg_we/cfg_index/cfg_data and must be changed only
// while the pipe is empty. func = 1 runs the keys in reverse order to decrypt.
module feistel_block_cipher_4round import fbc_pkg::*; #(
  parameter int unsigned ROUNDS     = ROUNDS_DEF,
  parameter int unsigned HALF_BYTES = HALF_BYTES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [KEY_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output out_item_t            out_data
);

  localparam int unsigned HALF_W = 8 * HALF_BYTES;

  key_set_t          keys;
  logic              vld   [ROUNDS+1];
  logic              rdy   [ROUNDS+1];
  logic              func  [ROUNDS];
  logic [HALF_W-1:0] left  [ROUNDS+1];
  logic [HALF_W-1:0] right [ROUNDS+1];

  fbc_key_file u_key_file (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .keys      (keys)
  );

  assign vld[0]   = in_valid;
  assign in_ready = rdy[0];
  assign func[0]  = in_data.func;
  assign left[0]  = in_data.block_left[HALF_W-1:0];
  assign right[0] = in_data.block_right[HALF_W-1:0];

  for (genvar r = 0; r < ROUNDS; r++) begin : g_round
    localparam int unsigned KE = r % KEY_COUNT;
    localparam int unsigned KD = (ROUNDS - 1 - r) % KEY_COUNT;
    if (r < ROUNDS - 1) begin : g_mid
      fbc_round_stage #(
        .HALF_BYTES (HALF_BYTES),
        .KEY_ENC    (KE),
        .KEY_DEC    (KD)
      ) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .keys      (keys),
        .in_valid  (vld[r]),
        .in_ready  (rdy[r]),
        .in_func   (func[r]),
        .in_left   (left[r]),
        .in_right  (right[r]),
        .out_valid (vld[r+1]),
        .out_ready (rdy[r+1]),
        .out_func  (func[r+1]),
        .out_left  (left[r+1]),
        .out_right (right[r+1])
      );
    end else begin : g_last
      fbc_round_stage #(
        .HALF_BYTES (HALF_BYTES),
        .KEY_ENC    (KE),
        .KEY_DEC    (KD)
      ) u_stage (
        .clk       (clk),
        .rst_n     (rst_n),
        .keys      (keys),
        .in_valid  (vld[r]),
        .in_ready  (rdy[r]),
        .in_func   (func[r]),
        .in_left   (left[r]),
        .in_right  (right[r]),
        .out_valid (vld[r+1]),
        .out_ready (rdy[r+1]),
        .out_func  (),
        .out_left  (left[r+1]),
        .out_right (right[r+1])
      );
    end
  end

  assign rdy[ROUNDS] = out_ready;
  assign out_valid   = vld[ROUNDS];

  // Swap halves after the last round.
  assign out_data.result_left  = BLOCK_W'(right[ROUNDS]);
  assign out_data.result_right = BLOCK_W'(left[ROUNDS]);

endmodule
